/* src/pidaw_pkg.sv */
// ----------------------------------------------------------------------------
// PID controller package
// Shared constants and saturation helpers for the PID controller block.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned OPA_W   = 49;
    localparam int unsigned ACC_W   = 56;
    localparam int unsigned PROD_W  = 72;
    localparam int unsigned STEPS   = DATA_W / DIGIT_W;

    localparam logic [1:0] MODE_HEADING = 2'd1;
    localparam logic [1:0] MODE_DEPTH   = 2'd2;

    localparam logic [ADDR_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_KP        = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_KI_SCALED = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_KD_SCALED = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_AW_GAIN   = 3'd4;
    localparam logic [ADDR_W-1:0] CFG_SAT_UPPER = 3'd5;
    localparam logic [ADDR_W-1:0] CFG_SAT_LOWER = 3'd6;
    localparam logic [ADDR_W-1:0] CFG_PCT_SCALE = 3'd7;

    localparam logic [2:0] OP_P   = 3'd0;
    localparam logic [2:0] OP_I   = 3'd1;
    localparam logic [2:0] OP_D   = 3'd2;
    localparam logic [2:0] OP_PCT = 3'd3;
    localparam logic [2:0] OP_AW  = 3'd4;

    localparam logic signed [33:0] HALF_TURN  = 34'sd11796480;
    localparam logic signed [33:0] FULL_TURN  = 34'sd23592960;
    localparam logic [32:0]        DEAD_LOW   = 33'd131072;
    localparam logic [32:0]        DEAD_HIGH  = 33'd327680;
    localparam logic signed [31:0] BANG_LEVEL = 32'sd3276800;

    localparam logic signed [31:0] MAX32 = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MIN32 = 32'sh80000000;
    localparam logic signed [47:0] MAX48 = 48'sh7FFFFFFFFFFF;
    localparam logic signed [47:0] MIN48 = 48'sh800000000000;

    function automatic logic signed [31:0] f_sat32_72(input logic signed [71:0] v);
        logic fits;
        fits = (&v[71:31]) | ~(|v[71:31]);
        if (fits) begin
            return v[31:0];
        end
        return v[71] ? MIN32 : MAX32;
    endfunction

    function automatic logic signed [47:0] f_sat48_72(input logic signed [71:0] v);
        logic fits;
        fits = (&v[71:47]) | ~(|v[71:47]);
        if (fits) begin
            return v[47:0];
        end
        return v[71] ? MIN48 : MAX48;
    endfunction

    function automatic logic signed [47:0] f_sat48_50(input logic signed [49:0] v);
        logic fits;
        fits = (&v[49:47]) | ~(|v[49:47]);
        if (fits) begin
            return v[47:0];
        end
        return v[49] ? MIN48 : MAX48;
    endfunction

    function automatic logic signed [31:0] f_sat32_50(input logic signed [49:0] v);
        logic fits;
        fits = (&v[49:31]) | ~(|v[49:31]);
        if (fits) begin
            return v[31:0];
        end
        return v[49] ? MIN32 : MAX32;
    endfunction

    function automatic logic signed [31:0] f_sat32_34(input logic signed [33:0] v);
        logic fits;
        fits = (&v[33:31]) | ~(|v[33:31]);
        if (fits) begin
            return v[31:0];
        end
        return v[33] ? MIN32 : MAX32;
    endfunction

endpackage

/* src/pid_controller_antiwindup_top.sv */
// ----------------------------------------------------------------------------
// PID controller with anti-windup
// Q16.16 PID loop with heading wrap, bang-bang band and deadband, clamping and
// back-calculation anti-windup, built around one digit-serial multiplier.
// ----------------------------------------------------------------------------
// The block takes one request at a time and works it through the single shared
// multiplier, which takes one 4-bit digit of the gain per cycle and forms up
// to five products per request (P, I, D, percent and windup), each followed
// by a capture step.
// A finished result waits in an output register, so a new request can be
// accepted while the previous result has not yet been taken.
module pid_controller_antiwindup_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0 up: setpoint[31:0], measurement[63:32].
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0 up: control_error[31:0], drive[63:32], drive_percent[95:64].
    output logic [95:0] m_axis_tdata
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ERR    = 4'd1;
    localparam logic [3:0] S_ESUM   = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_CAPT   = 4'd4;
    localparam logic [3:0] S_PID    = 4'd5;
    localparam logic [3:0] S_CLAMP  = 4'd6;
    localparam logic [3:0] S_PCTLD  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]         r_state;
    logic [1:0]         r_mode;
    logic signed [31:0] r_kp, r_ki, r_kd, r_aw, r_upper, r_lower, r_pct_scale;
    logic signed [31:0] r_prev_error, r_windup;
    logic signed [47:0] r_esum;

    logic signed [31:0] r_sp, r_meas, r_err;
    logic signed [47:0] r_p, r_i, r_d;
    logic signed [31:0] r_pid, r_mid, r_drive, r_pct;
    logic signed [33:0] r_pidv;

    logic [2:0]                r_op;
    logic [2:0]                r_cnt;
    logic signed [48:0]        r_mul_a;
    logic [31:0]               r_mul_b;
    logic signed [55:0]        r_hi;
    logic [31:0]               r_lo;

    logic        r_out_valid;
    logic [95:0] r_out_data;

    logic               w_heading, w_depth;
    logic signed [33:0] w_diff, w_wrapped;
    logic signed [49:0] w_esum_add, w_pid_add;
    logic signed [4:0]  w_dig;
    logic signed [55:0] w_pp, w_sum;
    logic signed [71:0] w_q;
    logic [32:0]        w_mag;
    logic signed [31:0] w_pid_raw, w_pid;
    logic signed [32:0] w_lim_sum;
    logic signed [33:0] w_pidv;
    logic signed [31:0] w_drive;
    logic               w_out_free;

    assign w_heading = (r_mode == pidaw_pkg::MODE_HEADING);
    assign w_depth   = (r_mode == pidaw_pkg::MODE_DEPTH);

    always_comb begin
        w_diff = {{2{r_sp[31]}}, r_sp} - {{2{r_meas[31]}}, r_meas};
        w_wrapped = w_diff;
        if (w_heading) begin
            if (w_diff > pidaw_pkg::HALF_TURN) begin
                w_wrapped = w_diff - pidaw_pkg::FULL_TURN;
            end else if (w_diff < -pidaw_pkg::HALF_TURN) begin
                w_wrapped = w_diff + pidaw_pkg::FULL_TURN;
            end
        end
    end

    assign w_esum_add = {{2{r_esum[47]}}, r_esum} + {{18{r_err[31]}}, r_err}
                        + {{18{r_windup[31]}}, r_windup};

    assign w_dig = (r_cnt == 3'(pidaw_pkg::STEPS - 1)) ?
                   $signed({r_mul_b[3], r_mul_b[3:0]}) : $signed({1'b0, r_mul_b[3:0]});
    assign w_pp  = r_mul_a * w_dig;
    assign w_sum = r_hi + w_pp;
    assign w_q   = {r_hi, r_lo[31:16]};

    assign w_pid_add = {{2{r_p[47]}}, r_p} + {{2{r_i[47]}}, r_i} + {{2{r_d[47]}}, r_d};
    assign w_pid_raw = pidaw_pkg::f_sat32_50(w_pid_add);
    assign w_mag     = r_err[31] ? (33'd0 - {r_err[31], r_err}) : {1'b0, r_err};

    always_comb begin
        w_pid = w_pid_raw;
        if (w_heading) begin
            if (w_mag > pidaw_pkg::DEAD_LOW && w_mag < pidaw_pkg::DEAD_HIGH) begin
                if (w_pid_raw > 32'sd0) begin
                    w_pid = pidaw_pkg::BANG_LEVEL;
                end else if (w_pid_raw < 32'sd0) begin
                    w_pid = -pidaw_pkg::BANG_LEVEL;
                end else begin
                    w_pid = 32'sd0;
                end
            end else if (w_mag != 33'd0 && w_mag < pidaw_pkg::DEAD_LOW) begin
                w_pid = 32'sd0;
            end
        end
    end

    assign w_lim_sum = {r_lower[31], r_lower} + {r_upper[31], r_upper};
    assign w_pidv    = {{2{r_pid[31]}}, r_pid} + {{2{r_mid[31]}}, r_mid};

    always_comb begin
        if (w_pidv > $signed({{2{r_upper[31]}}, r_upper})) begin
            w_drive = r_upper;
        end else if (w_pidv < $signed({{2{r_lower[31]}}, r_lower})) begin
            w_drive = r_lower;
        end else begin
            w_drive = w_pidv[31:0];
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 2'd0;
            r_kp         <= '0;
            r_ki         <= '0;
            r_kd         <= '0;
            r_aw         <= '0;
            r_upper      <= '0;
            r_lower      <= '0;
            r_pct_scale  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pidaw_pkg::CFG_MODE:      r_mode      <= i_cfg_data[1:0];
                pidaw_pkg::CFG_KP:        r_kp        <= i_cfg_data;
                pidaw_pkg::CFG_KI_SCALED: r_ki        <= i_cfg_data;
                pidaw_pkg::CFG_KD_SCALED: r_kd        <= i_cfg_data;
                pidaw_pkg::CFG_AW_GAIN:   r_aw        <= i_cfg_data;
                pidaw_pkg::CFG_SAT_UPPER: r_upper     <= i_cfg_data;
                pidaw_pkg::CFG_SAT_LOWER: r_lower     <= i_cfg_data;
                pidaw_pkg::CFG_PCT_SCALE: r_pct_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_prev_error <= '0;
            r_esum       <= '0;
            r_windup     <= '0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_sp    <= s_axis_tdata[31:0];
                        r_meas  <= s_axis_tdata[63:32];
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= pidaw_pkg::f_sat32_34(w_wrapped);
                    r_state <= S_ESUM;
                end
                S_ESUM: begin
                    r_esum  <= pidaw_pkg::f_sat48_50(w_esum_add);
                    r_mul_a <= {{17{r_err[31]}}, r_err};
                    r_mul_b <= r_kp;
                    r_op    <= pidaw_pkg::OP_P;
                    r_cnt   <= '0;
                    r_hi    <= '0;
                    r_lo    <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_hi    <= w_sum >>> pidaw_pkg::DIGIT_W;
                    r_lo    <= {w_sum[3:0], r_lo[31:4]};
                    r_mul_b <= r_mul_b >> pidaw_pkg::DIGIT_W;
                    r_cnt   <= r_cnt + 3'd1;
                    if (r_cnt == 3'(pidaw_pkg::STEPS - 1)) begin
                        r_state <= S_CAPT;
                    end
                end
                S_CAPT: begin
                    r_cnt <= '0;
                    r_hi  <= '0;
                    r_lo  <= '0;
                    case (r_op)
                        pidaw_pkg::OP_P: begin
                            r_p     <= pidaw_pkg::f_sat48_72(w_q);
                            r_mul_a <= {r_esum[47], r_esum};
                            r_mul_b <= r_ki;
                            r_op    <= pidaw_pkg::OP_I;
                            r_state <= S_MUL;
                        end
                        pidaw_pkg::OP_I: begin
                            r_i     <= pidaw_pkg::f_sat48_72(w_q);
                            r_mul_a <= {{17{r_err[31]}}, r_err}
                                       - {{17{r_prev_error[31]}}, r_prev_error};
                            r_mul_b <= r_kd;
                            r_op    <= pidaw_pkg::OP_D;
                            r_state <= S_MUL;
                        end
                        pidaw_pkg::OP_D: begin
                            r_d     <= pidaw_pkg::f_sat48_72(w_q);
                            r_state <= S_PID;
                        end
                        pidaw_pkg::OP_PCT: begin
                            r_pct   <= pidaw_pkg::f_sat32_72(w_q);
                            r_mul_a <= {{17{r_drive[31]}}, r_drive}
                                       - {{15{r_pidv[33]}}, r_pidv};
                            r_mul_b <= r_aw;
                            r_op    <= pidaw_pkg::OP_AW;
                            r_state <= S_MUL;
                        end
                        default: begin
                            r_windup <= pidaw_pkg::f_sat32_72(w_q);
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_PID: begin
                    r_pid        <= w_pid;
                    r_mid        <= w_lim_sum[32:1];
                    r_prev_error <= r_err;
                    r_state      <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (w_depth) begin
                        r_drive <= r_pid;
                        r_pct   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_drive <= w_drive;
                        r_pidv  <= w_pidv;
                        r_state <= S_PCTLD;
                    end
                end
                S_PCTLD: begin
                    r_mul_a <= {{17{r_drive[31]}}, r_drive} - {{17{r_mid[31]}}, r_mid};
                    r_mul_b <= r_pct_scale;
                    r_op    <= pidaw_pkg::OP_PCT;
                    r_cnt   <= '0;
                    r_hi    <= '0;
                    r_lo    <= '0;
                    r_state <= S_MUL;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_data  <= {r_pct, r_drive, r_err};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the anti-windup PID controller
// Streams setpoint and measurement requests through the controller while the
// gains, limits and mode are changed between phases, and checks every returned
// error, drive and drive percent against an in-bench model of the loop.
// ----------------------------------------------------------------------------
module tb;

    localparam int ONE = 65536;
    localparam logic signed [95:0] ONE_W = 96'sd65536;
    localparam logic [1:0] MODE_CLAMPED = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int MAX_REQUESTS = 2048;
    localparam int RANDOM_SAMPLES = 1450;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT = 1500000;

    typedef enum logic {ENTRY_SAMPLE, ENTRY_WRITE} t_entry_kind;

    typedef struct {
        t_entry_kind kind;
        logic [31:0] setpoint;
        logic [31:0] measurement;
        logic [2:0]  reg_addr;
        logic [31:0] reg_value;
    } t_loop_entry;

    typedef struct packed {
        logic signed [31:0] drive_percent;
        logic signed [31:0] drive;
        logic signed [31:0] control_error;
    } t_loop_output;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;

    pid_controller_antiwindup_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Loop model: configuration copy and controller state.
    logic [1:0]         loop_mode = MODE_CLAMPED;
    logic signed [31:0] gain_p = '0;
    logic signed [31:0] gain_i = '0;
    logic signed [31:0] gain_d = '0;
    logic signed [31:0] gain_aw = '0;
    logic signed [31:0] limit_hi = '0;
    logic signed [31:0] limit_lo = '0;
    logic signed [31:0] gain_pct = '0;
    logic signed [31:0] last_error = '0;
    logic signed [47:0] error_acc = '0;
    logic signed [31:0] windup = '0;

    t_loop_entry  pending [$];
    t_loop_output expected_outputs [MAX_REQUESTS];

    int req_count = 0;
    int req_posted = 0;
    int rsp_count = 0;
    int errors = 0;
    int samples_queued = 0;
    int settings_count = 0;
    int heading_seen = 0;
    int depth_seen = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int snd_calm = 0;
    int rcv_calm = 0;

    function automatic logic signed [95:0] clip(input logic signed [95:0] v, input int bits);
        logic signed [95:0] hi;
        hi = (96'sd1 <<< (bits - 1)) - 96'sd1;
        if (v > hi) begin
            return hi;
        end
        if (v < ~hi) begin
            return ~hi;
        end
        return v;
    endfunction

    // Fixed-point product, rounded toward minus infinity.
    function automatic logic signed [95:0] qmul(input logic signed [95:0] a,
                                                input logic signed [95:0] b);
        logic signed [95:0] prod;
        prod = a * b;
        return prod >>> 16;
    endfunction

    function automatic t_loop_output advance_loop(input logic signed [31:0] sp,
                                                  input logic signed [31:0] meas);
        logic signed [95:0] e, p, i, d, pid, mag, mid, level, drv, pct, acc, wup;
        t_loop_output r;
        e = 96'(sp) - 96'(meas);
        if (loop_mode == pidaw_pkg::MODE_HEADING) begin
            if (e > 180 * ONE_W) begin
                e = e - 360 * ONE_W;
            end else if (e < -180 * ONE_W) begin
                e = e + 360 * ONE_W;
            end
        end
        e = clip(e, 32);
        acc = clip(96'(error_acc) + e + 96'(windup), 48);
        error_acc = acc[47:0];
        p = clip(qmul(e, 96'(gain_p)), 48);
        i = clip(qmul(96'(error_acc), 96'(gain_i)), 48);
        d = clip(qmul(e - 96'(last_error), 96'(gain_d)), 48);
        pid = clip(p + i + d, 32);
        last_error = e[31:0];
        if (loop_mode == pidaw_pkg::MODE_HEADING) begin
            mag = (e < 0) ? -e : e;
            if (mag > 2 * ONE_W && mag < 5 * ONE_W) begin
                pid = (pid > 0) ? 50 * ONE_W : ((pid < 0) ? -50 * ONE_W : 96'sd0);
            end else if (mag > 0 && mag < 2 * ONE_W) begin
                pid = 96'sd0;
            end
        end
        if (loop_mode == pidaw_pkg::MODE_DEPTH) begin
            drv = pid;
            pct = 96'sd0;
        end else begin
            mid = 96'(limit_lo);
            mid = (mid + 96'(limit_hi)) >>> 1;
            level = pid + mid;
            if (level > 96'(limit_hi)) begin
                drv = 96'(limit_hi);
            end else if (level < 96'(limit_lo)) begin
                drv = 96'(limit_lo);
            end else begin
                drv = level;
            end
            drv = clip(drv, 32);
            pct = clip(qmul(drv - mid, 96'(gain_pct)), 32);
            wup = clip(qmul(drv - level, 96'(gain_aw)), 32);
            windup = wup[31:0];
        end
        r.control_error = e[31:0];
        r.drive = drv[31:0];
        r.drive_percent = pct[31:0];
        return r;
    endfunction

    function automatic void apply_register(input logic [2:0] addr, input logic [31:0] value);
        case (addr)
            pidaw_pkg::CFG_MODE:      loop_mode = value[1:0];
            pidaw_pkg::CFG_KP:        gain_p = value;
            pidaw_pkg::CFG_KI_SCALED: gain_i = value;
            pidaw_pkg::CFG_KD_SCALED: gain_d = value;
            pidaw_pkg::CFG_AW_GAIN:   gain_aw = value;
            pidaw_pkg::CFG_SAT_UPPER: limit_hi = value;
            pidaw_pkg::CFG_SAT_LOWER: limit_lo = value;
            pidaw_pkg::CFG_PCT_SCALE: gain_pct = value;
            default: ;
        endcase
    endfunction

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 4);
        end
        if (r < 97) begin
            return $urandom_range(5, 20);
        end
        return $urandom_range(30, 90);
    endfunction

    function automatic logic [31:0] pick_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
        end
        if (r < 8) begin
            return $urandom();
        end
        if (r == 8) begin
            return '0;
        end
        return $urandom_range(0, 1) ? pidaw_pkg::MAX32 : pidaw_pkg::MIN32;
    endfunction

    task automatic queue_sample(input logic [31:0] sp, input logic [31:0] meas);
        t_loop_entry ent;
        ent.kind = ENTRY_SAMPLE;
        ent.setpoint = sp;
        ent.measurement = meas;
        ent.reg_addr = '0;
        ent.reg_value = '0;
        pending.push_back(ent);
        samples_queued++;
    endtask

    task automatic queue_write(input logic [2:0] addr, input logic [31:0] value);
        t_loop_entry ent;
        ent.kind = ENTRY_WRITE;
        ent.setpoint = '0;
        ent.measurement = '0;
        ent.reg_addr = addr;
        ent.reg_value = value;
        pending.push_back(ent);
    endtask

    task automatic queue_settings(input logic [1:0] mode, input logic [31:0] kp,
                                  input logic [31:0] ki, input logic [31:0] kd,
                                  input logic [31:0] aw, input logic [31:0] hi,
                                  input logic [31:0] lo, input logic [31:0] pct);
        queue_write(pidaw_pkg::CFG_MODE, {30'd0, mode});
        queue_write(pidaw_pkg::CFG_KP, kp);
        queue_write(pidaw_pkg::CFG_KI_SCALED, ki);
        queue_write(pidaw_pkg::CFG_KD_SCALED, kd);
        queue_write(pidaw_pkg::CFG_AW_GAIN, aw);
        queue_write(pidaw_pkg::CFG_SAT_UPPER, hi);
        queue_write(pidaw_pkg::CFG_SAT_LOWER, lo);
        queue_write(pidaw_pkg::CFG_PCT_SCALE, pct);
        settings_count++;
    endtask

    // Request side. Register writes wait until every request has been answered.
    always @(posedge i_clk) begin
        logic valid_n;
        logic we_n;
        t_loop_entry head;
        valid_n = s_axis_tvalid;
        we_n = 1'b0;
        if (!i_rst_n) begin
            valid_n = 1'b0;
        end else begin
            if (snd_calm > 0) begin
                snd_calm--;
            end else if ($urandom_range(0, 599) == 0) begin
                snd_calm = $urandom_range(200, 1200);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (loop_mode == pidaw_pkg::MODE_HEADING) begin
                    heading_seen++;
                end
                if (loop_mode == pidaw_pkg::MODE_DEPTH) begin
                    depth_seen++;
                end
                expected_outputs[req_count] = advance_loop(s_axis_tdata[31:0],
                                                           s_axis_tdata[63:32]);
                req_count++;
                valid_n = 1'b0;
            end
            if (!valid_n && gap_left > 0) begin
                gap_left--;
            end else if (!valid_n && pending.size() > 0) begin
                head = pending[0];
                if (head.kind == ENTRY_SAMPLE) begin
                    valid_n = 1'b1;
                    s_axis_tdata <= {head.measurement, head.setpoint};
                    void'(pending.pop_front());
                    gap_left = (snd_calm > 0) ? 0 : idle_span();
                end else if (rsp_count == req_count) begin
                    we_n = 1'b1;
                    i_cfg_addr <= head.reg_addr;
                    i_cfg_data <= head.reg_value;
                    apply_register(head.reg_addr, head.reg_value);
                    void'(pending.pop_front());
                end
            end
        end
        s_axis_tvalid <= valid_n;
        i_cfg_we <= we_n;
        req_posted <= req_count;
    end

    // Result side.
    always @(posedge i_clk) begin
        t_loop_output want;
        t_loop_output got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_loop_output'(m_axis_tdata);
                if (rsp_count < req_posted) begin
                    want = expected_outputs[rsp_count];
                    if (got.control_error !== want.control_error) begin
                        $error("control_error: expected %0d, got %0d",
                               want.control_error, got.control_error);
                        errors++;
                    end
                    if (got.drive !== want.drive) begin
                        $error("drive: expected %0d, got %0d", want.drive, got.drive);
                        errors++;
                    end
                    if (got.drive_percent !== want.drive_percent) begin
                        $error("drive_percent: expected %0d, got %0d",
                               want.drive_percent, got.drive_percent);
                        errors++;
                    end
                    rsp_count <= rsp_count + 1;
                end else begin
                    $error("result with no request outstanding: %h", m_axis_tdata);
                    errors++;
                end
            end
            if (rcv_calm > 0) begin
                rcv_calm--;
            end else if ($urandom_range(0, 599) == 0) begin
                rcv_calm = $urandom_range(200, 1200);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (rcv_calm == 0 && $urandom_range(0, 7) == 0) begin
                    stall_left = idle_span();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout with %0d of %0d requests answered", rsp_count, req_count);
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int span;
        int r;
        int base;
        int lo_v;
        int hi_v;
        logic [31:0] sp;
        logic [31:0] meas;

        // Registers still at their reset values.
        queue_sample(pidaw_pkg::MAX32, pidaw_pkg::MIN32);
        queue_sample(pidaw_pkg::MIN32, pidaw_pkg::MAX32);
        queue_sample('0, '0);

        queue_settings(MODE_CLAMPED, 2 * ONE, ONE / 4, ONE / 2, ONE / 2,
                       100 * ONE, -20 * ONE, 163840);
        queue_sample(10 * ONE, 4 * ONE);
        queue_sample(50 * ONE, -300 * ONE);
        queue_sample(-300 * ONE, 50 * ONE);
        queue_sample(pidaw_pkg::MAX32, pidaw_pkg::MIN32);
        queue_sample(pidaw_pkg::MIN32, pidaw_pkg::MAX32);

        // Heading: wrap edges, bang-bang band, deadband and the band borders.
        queue_settings(pidaw_pkg::MODE_HEADING, ONE, '0, ONE / 8, ONE, 90 * ONE,
                       -90 * ONE, '0);
        queue_sample(181 * ONE, '0);
        queue_sample('0, 181 * ONE);
        queue_sample(180 * ONE, '0);
        queue_sample(-180 * ONE, '0);
        queue_sample(3 * ONE, '0);
        queue_sample(-3 * ONE, '0);
        queue_sample(ONE, '0);
        queue_sample(2 * ONE, '0);
        queue_sample(5 * ONE, '0);
        queue_sample('0, '0);
        queue_sample(pidaw_pkg::MAX32, pidaw_pkg::MIN32);

        // Heading with a zero PID sum inside the bang-bang band.
        queue_settings(pidaw_pkg::MODE_HEADING, '0, '0, '0, '0, 10 * ONE, -30 * ONE, ONE);
        queue_sample(3 * ONE, '0);

        queue_settings(pidaw_pkg::MODE_DEPTH, pidaw_pkg::MAX32, pidaw_pkg::MAX32,
                       pidaw_pkg::MIN32, ONE, 10 * ONE, -10 * ONE, ONE);
        queue_sample(pidaw_pkg::MAX32, pidaw_pkg::MIN32);
        queue_sample(pidaw_pkg::MIN32, pidaw_pkg::MAX32);
        queue_sample(ONE, '0);

        // Spare mode with the limits given the wrong way round.
        queue_settings(MODE_SPARE, ONE, ONE / 16, ONE / 4, -ONE, -50 * ONE, 50 * ONE, -ONE);
        queue_sample(10 * ONE, '0);
        queue_sample(-10 * ONE, '0);

        samples_queued = 0;
        while (samples_queued < RANDOM_SAMPLES) begin
            r = $urandom_range(0, 9);
            base = int'($urandom_range(0, 400 * ONE)) - 200 * ONE;
            hi_v = base + int'($urandom_range(0, 200 * ONE));
            lo_v = base - int'($urandom_range(0, 200 * ONE));
            if (r >= 6 && r < 8) begin
                hi_v = $urandom();
                lo_v = $urandom();
            end else if (r == 8) begin
                base = hi_v;
                hi_v = lo_v;
                lo_v = base;
            end else if (r == 9) begin
                hi_v = pidaw_pkg::MAX32;
                lo_v = pidaw_pkg::MIN32;
            end
            queue_settings(2'($urandom_range(0, 3)), pick_gain(), pick_gain(), pick_gain(),
                           pick_gain(), hi_v, lo_v, pick_gain());
            span = $urandom_range(15, 110);
            repeat (span) begin
                r = $urandom_range(0, 9);
                if (r < 5) begin
                    sp = int'($urandom_range(0, 400 * ONE)) - 200 * ONE;
                    meas = sp - (int'($urandom_range(0, 12 * ONE)) - 6 * ONE);
                end else if (r < 8) begin
                    sp = int'($urandom_range(0, 800 * ONE)) - 400 * ONE;
                    meas = int'($urandom_range(0, 800 * ONE)) - 400 * ONE;
                end else begin
                    sp = $urandom();
                    meas = $urandom();
                end
                queue_sample(sp, meas);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || s_axis_tvalid || rsp_count != req_count) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("tb: %0d requests answered over %0d register settings", rsp_count,
                 settings_count);
        $display("tb: %0d of them in heading mode, %0d in depth mode, %0d mismatches",
                 heading_seen, depth_seen, errors);
        if (errors == 0 && rsp_count == req_count) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
